>>> design/lfat_pkg.sv
`default_nettype none

package lfat_pkg;

  localparam int unsigned GAIN_W      = 9;
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [GAIN_W-1:0] GAIN_ONE = 9'd256;

  localparam logic [CHAR_W-1:0] CHAR_DOLLAR = 8'h24;
  localparam logic [CHAR_W-1:0] CHAR_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_MINUS  = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_CR     = 8'h0D;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_HEAD  = 7'b0000010,
    S_CONV  = 7'b0000100,
    S_SIGN  = 7'b0001000,
    S_DIGIT = 7'b0010000,
    S_SEP   = 7'b0100000,
    S_CR    = 7'b1000000
  } fmt_state_e;

endpackage

`default_nettype wire

>>> design/lfat_front.sv
`default_nettype none

module lfat_front #(
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [lfat_pkg::GAIN_W-1:0]       cfg_wdata_i,
  input  wire logic                              push,
  output logic                                   full,
  input  wire logic [SAMPLE_WIDTH-1:0]           raw_sample_i,
  input  wire logic                              q_full_i,
  output logic                                   q_push_o,
  output logic [2*SAMPLE_WIDTH-1:0]              q_wdata_o
);
  import lfat_pkg::*;

  localparam int unsigned SW = SAMPLE_WIDTH;
  localparam int unsigned PW = SW + GAIN_W + 2;

  logic [GAIN_W-1:0]    gain_q;
  logic [GAIN_W-1:0]    gain_eff;
  logic                 s1_q, s2_q;
  logic [SW-1:0]        raw_q;
  logic [SW-1:0]        filt_q, filt_d;
  logic signed [SW:0]   diff;
  logic signed [GAIN_W:0] gain_s;
  logic signed [PW-1:0] prod_d, prod_q;
  logic signed [PW-1:0] adj;
  logic signed [PW-1:0] delta;
  logic                 accept;

  // clamp out-of-range gains to unity
  assign gain_eff = gain_q[GAIN_W-1] ? GAIN_ONE : gain_q;
  assign gain_s   = {1'b0, gain_eff};

  assign accept = push && !full;
  assign full   = s1_q || s2_q || q_full_i;

  assign diff   = $signed({raw_q[SW-1], raw_q}) - $signed({filt_q[SW-1], filt_q});
  assign prod_d = diff * gain_s;

  // bias negative products so the shift truncates toward zero
  assign adj    = prod_q + (prod_q[PW-1] ? PW'(255) : PW'(0));
  assign delta  = adj >>> 8;
  assign filt_d = filt_q + delta[SW-1:0];

  assign q_push_o  = s2_q;
  assign q_wdata_o = {raw_q, filt_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GAIN_ONE;
      s1_q   <= 1'b0;
      s2_q   <= 1'b0;
      filt_q <= '0;
    end else begin
      if (cfg_we_i) begin
        gain_q <= cfg_wdata_i;
      end
      s1_q <= accept;
      s2_q <= s1_q;
      if (s2_q) begin
        filt_q <= filt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      raw_q <= raw_sample_i;
    end
    if (s1_q) begin
      prod_q <= prod_d;
    end
  end

endmodule

`default_nettype wire

>>> design/lfat_fifo.sv
`default_nettype none

module lfat_fifo #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      rdata_o,
  output logic                  full_o,
  output logic                  empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, rptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= wrap_inc(wptr_q);
      end
      if (do_pop) begin
        rptr_q <= wrap_inc(rptr_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

>>> design/lfat_back.sv
`default_nettype none

module lfat_back #(
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         q_empty_i,
  input  wire logic [2*SAMPLE_WIDTH-1:0]    q_rdata_i,
  output logic                              q_pop_o,
  output logic                              empty,
  input  wire logic                         pop,
  output logic [lfat_pkg::CHAR_W-1:0]       ascii_char_o,
  output logic                              line_end_o
);
  import lfat_pkg::*;

  localparam int unsigned SW    = SAMPLE_WIDTH;
  localparam int unsigned ND    = (((SW - 1) * 1233) >> 12) + 1;
  localparam int unsigned IDX_W = (ND > 1) ? $clog2(ND) : 1;
  localparam int unsigned CNT_W = $clog2(SW + 1);

  fmt_state_e          state_q, state_d;
  logic [SW-1:0]       raw_q, filt_q;
  logic                sel_q, sel_d;
  logic                neg_q, neg_d;
  logic [SW-1:0]       mag_q, mag_d;
  logic [ND*4-1:0]     bcd_q, bcd_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic                started_q, started_d;
  logic                load;
  logic                out_valid_q;
  logic [CHAR_W-1:0]   out_char_q, char_d;
  logic                out_end_q, end_d;
  logic                emit;
  logic                can_emit;
  logic [SW-1:0]       src;
  logic [3:0]          digit;
  logic [ND*4-1:0]     bcd_adj;

  assign can_emit = !out_valid_q || pop;
  assign empty        = !out_valid_q;
  assign ascii_char_o = out_char_q;
  assign line_end_o   = out_end_q;

  assign src   = sel_d ? filt_q : raw_q;
  assign digit = bcd_q[idx_q*4 +: 4];

  always_comb begin
    for (int i = 0; i < ND; i++) begin
      bcd_adj[i*4 +: 4] = (bcd_q[i*4 +: 4] >= 4'd5) ? bcd_q[i*4 +: 4] + 4'd3
                                                   : bcd_q[i*4 +: 4];
    end
  end

  always_comb begin
    state_d   = state_q;
    sel_d     = sel_q;
    neg_d     = neg_q;
    mag_d     = mag_q;
    bcd_d     = bcd_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    started_d = started_q;
    load      = 1'b0;
    emit      = 1'b0;
    char_d    = CHAR_SPACE;
    end_d     = 1'b0;
    q_pop_o   = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          state_d = S_HEAD;
        end
      end
      S_HEAD: begin
        if (can_emit) begin
          emit    = 1'b1;
          char_d  = CHAR_DOLLAR;
          sel_d   = 1'b0;
          load    = 1'b1;
          state_d = S_CONV;
        end
      end
      S_CONV: begin
        // one shift-and-correct step per cycle
        {bcd_d, mag_d} = {bcd_adj, mag_q} << 1;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          state_d = S_SIGN;
        end
      end
      S_SIGN: begin
        idx_d     = IDX_W'(ND - 1);
        started_d = 1'b0;
        if (!neg_q) begin
          state_d = S_DIGIT;
        end else if (can_emit) begin
          emit    = 1'b1;
          char_d  = CHAR_MINUS;
          state_d = S_DIGIT;
        end
      end
      S_DIGIT: begin
        if (!started_q && digit == 4'd0 && idx_q != '0) begin
          // drop leading zero
          idx_d = idx_q - 1'b1;
        end else if (can_emit) begin
          emit      = 1'b1;
          char_d    = CHAR_ZERO + {4'd0, digit};
          started_d = 1'b1;
          if (idx_q == '0) begin
            state_d = S_SEP;
          end else begin
            idx_d = idx_q - 1'b1;
          end
        end
      end
      S_SEP: begin
        if (can_emit) begin
          emit   = 1'b1;
          char_d = CHAR_SPACE;
          if (!sel_q) begin
            sel_d   = 1'b1;
            load    = 1'b1;
            state_d = S_CONV;
          end else begin
            state_d = S_CR;
          end
        end
      end
      S_CR: begin
        if (can_emit) begin
          emit    = 1'b1;
          char_d  = CHAR_CR;
          end_d   = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (load) begin
      neg_d = src[SW-1];
      mag_d = src[SW-1] ? (~src + 1'b1) : src;
      bcd_d = '0;
      cnt_d = CNT_W'(SW);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      raw_q  <= q_rdata_i[2*SW-1:SW];
      filt_q <= q_rdata_i[SW-1:0];
    end
    sel_q     <= sel_d;
    neg_q     <= neg_d;
    mag_q     <= mag_d;
    bcd_q     <= bcd_d;
    cnt_q     <= cnt_d;
    idx_q     <= idx_d;
    started_q <= started_d;
    if (emit) begin
      out_char_q <= char_d;
      out_end_q  <= end_d;
    end
  end

endmodule

`default_nettype wire

>>> design/lowpass_filter_ascii_telemetry.sv
// Path: a sample beat passes front registers s1_q and s2_q into the queue, then the
//   formatter pops it and sends the '$' beat. Each line is paced by pop stalls and
//   by the bit-per-cycle decimal conversion of each number, ND = 5 digit positions at 16 bits.
// Throughput: one sample per line; the front takes no new beat until the last is queued,
//   and the two-entry queue absorbs bursts.
// Reset: rst_ni low clears the filter state, sets unity gain, empties the queue.
`default_nettype none

module lowpass_filter_ascii_telemetry #(
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // gain register write
  input  wire logic                          cfg_we_i,
  input  wire logic [lfat_pkg::GAIN_W-1:0]   cfg_wdata_i,
  // sample side
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [SAMPLE_WIDTH-1:0]       raw_sample_i,
  // character side
  output logic                               empty,
  input  wire logic                          pop,
  output logic [lfat_pkg::CHAR_W-1:0]        ascii_char_o,
  output logic                               line_end_o
);
  import lfat_pkg::*;

  localparam int unsigned EW = 2 * SAMPLE_WIDTH;

  logic          q_push, q_pop, q_full, q_empty;
  logic [EW-1:0] q_wdata, q_rdata;

  // Front: take a sample beat, update the low-pass state, queue raw and filtered.
  lfat_front #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .push         (push),
    .full         (full),
    .raw_sample_i (raw_sample_i),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_wdata_o    (q_wdata)
  );

  // Hold finished value pairs so the front and the formatter stall apart.
  lfat_fifo #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // Back: convert each pair to decimal and send one character beat at a time.
  lfat_back #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_rdata_i    (q_rdata),
    .q_pop_o      (q_pop),
    .empty        (empty),
    .pop          (pop),
    .ascii_char_o (ascii_char_o),
    .line_end_o   (line_end_o)
  );

endmodule

`default_nettype wire

>>> tb/sv/telemetry_line_checker.sv
`timescale 1ns / 1ps

module telemetry_line_checker #(
  parameter int unsigned SAMPLE_W = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lfat_pkg::GAIN_W-1:0]   cfg_wdata_i,
  input  logic                          push_i,
  input  logic                          full_i,
  input  logic [SAMPLE_W-1:0]           raw_sample_i,
  input  logic                          empty_i,
  input  logic                          pop_i,
  input  logic [lfat_pkg::CHAR_W-1:0]   ascii_char_i,
  input  logic                          line_end_i,
  output int                            pending_o,
  output int                            fail_count_o
);
  import lfat_pkg::*;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } tele_char_t;

  tele_char_t        line_chars_q[$];
  logic [GAIN_W-1:0] gain_q;
  int                filtered_q;
  int                fail_total;

  initial begin
    fail_total   = 0;
    fail_count_o = 0;
    pending_o    = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fail_total++;
  endtask

  // Gains above unity act as unity; the division truncates toward zero.
  function automatic int filter_update(input int state, input int sample,
                                       input logic [GAIN_W-1:0] gain);
    int g;
    g = (gain > GAIN_ONE) ? int'(GAIN_ONE) : int'(gain);
    return state + ((sample - state) * g) / int'(GAIN_ONE);
  endfunction

  task automatic add_char(input logic [CHAR_W-1:0] c, input logic last);
    line_chars_q.push_back('{code: c, last: last});
  endtask

  task automatic add_number(input int v);
    int                mag;
    logic [CHAR_W-1:0] digits[$];
    if (v < 0) begin
      add_char(CHAR_MINUS, 1'b0);
      mag = -v;
    end else begin
      mag = v;
    end
    do begin
      digits.push_front(CHAR_ZERO + CHAR_W'(mag % 10));
      mag = mag / 10;
    end while (mag > 0);
    foreach (digits[i]) add_char(digits[i], 1'b0);
  endtask

  task automatic build_line(input int sample);
    filtered_q = filter_update(filtered_q, sample, gain_q);
    add_char(CHAR_DOLLAR, 1'b0);
    add_number(sample);
    add_char(CHAR_SPACE, 1'b0);
    add_number(filtered_q);
    add_char(CHAR_SPACE, 1'b0);
    add_char(CHAR_CR, 1'b1);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    tele_char_t want;
    if (!rst_ni) begin
      gain_q     = GAIN_ONE;
      filtered_q = 0;
      line_chars_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) gain_q = cfg_wdata_i;
      if (pop_i && !empty_i) begin
        if (line_chars_q.size() == 0) begin
          report_mismatch($sformatf("character 0x%02h with nothing expected", ascii_char_i));
        end else begin
          want = line_chars_q.pop_front();
          if (ascii_char_i !== want.code)
            report_mismatch($sformatf("ascii_char 0x%02h, expected 0x%02h",
                                      ascii_char_i, want.code));
          if (line_end_i !== want.last)
            report_mismatch($sformatf("line_end %b, expected %b", line_end_i, want.last));
        end
      end
      if (push_i && !full_i) build_line(int'($signed(raw_sample_i)));
      pending_o    <= line_chars_q.size();
      fail_count_o <= fail_total;
    end
  end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import lfat_pkg::*;

  localparam int unsigned SAMPLE_W = 16;
  // Even with long pop stalls, a gap without any beat that reaches WATCHDOG_LIMIT
  // means a hang.
  localparam int WATCHDOG_LIMIT = 4000;

  logic                clk_i      = 1'b0;
  logic                rst_ni     = 1'b0;
  logic                cfg_we     = 1'b0;
  logic [GAIN_W-1:0]   cfg_wdata  = '0;
  logic                push       = 1'b0;
  logic                full;
  logic [SAMPLE_W-1:0] raw_sample = '0;
  logic                empty;
  logic                pop        = 1'b0;
  logic [CHAR_W-1:0]   ascii_char;
  logic                line_end;

  int pending;
  int fail_count;
  int send_idle_pct = 33;
  int recv_idle_pct = 45;
  int quiet_cycles  = 0;

  // 12 ns period
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  lowpass_filter_ascii_telemetry #(
    .SAMPLE_WIDTH(SAMPLE_W)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .push        (push),
    .full        (full),
    .raw_sample_i(raw_sample),
    .empty       (empty),
    .pop         (pop),
    .ascii_char_o(ascii_char),
    .line_end_o  (line_end)
  );

  telemetry_line_checker #(
    .SAMPLE_W(SAMPLE_W)
  ) checker_u (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .push_i      (push),
    .full_i      (full),
    .raw_sample_i(raw_sample),
    .empty_i     (empty),
    .pop_i       (pop),
    .ascii_char_i(ascii_char),
    .line_end_i  (line_end),
    .pending_o   (pending),
    .fail_count_o(fail_count)
  );

  // Receiver: stall pop at random, one fresh decision per cycle so that
  // stalls land on every phase of the line.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Watchdog: end the run once no beat has moved on either side for too long.
  always @(posedge clk_i) begin
    if (rst_ni && ((push && !full) || (pop && !empty))) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Offer one sample and hold it until accepted. Push stays high on return so
  // that back-to-back samples never see push dropped and raised in one step.
  task automatic send_sample(input logic [SAMPLE_W-1:0] v);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push       <= 1'b1;
    raw_sample <= v;
    do @(posedge clk_i); while (full);
  endtask

  // Drop push and hold until every character expected so far has been popped.
  task automatic drain;
    push <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Write the gain only with the block idle.
  task automatic set_gain(input logic [GAIN_W-1:0] g);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= g;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // Bias towards the extremes and small magnitudes, where the sign and the
  // digit count change; the rest covers every bit pattern.
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return {1'b1, {(SAMPLE_W-1){1'b0}}};
      1:       return {1'b0, {(SAMPLE_W-1){1'b1}}};
      2:       return SAMPLE_W'($urandom_range(0, 40)) - SAMPLE_W'(20);
      3:       return SAMPLE_W'($urandom_range(0, 2000)) - SAMPLE_W'(1000);
      default: return SAMPLE_W'($urandom());
    endcase
  endfunction

  initial begin : stimulus
    logic [GAIN_W-1:0] phase_gain[8];

    phase_gain[0] = 9'd255;
    phase_gain[1] = GAIN_W'($urandom_range(257, 511));
    phase_gain[2] = GAIN_W'($urandom_range(0, 511));
    phase_gain[3] = '0;
    phase_gain[4] = GAIN_W'($urandom_range(1, 64));
    phase_gain[5] = GAIN_ONE;
    phase_gain[6] = GAIN_W'($urandom_range(0, 511));
    phase_gain[7] = '1;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: unity gain out of reset, so the line repeats the sample.
    send_sample(16'sd0);
    send_sample(16'sd32767);
    send_sample(-16'sd32768);
    send_sample(-16'sd1);
    send_sample(16'sd1);
    send_sample(16'sd9);
    send_sample(16'sd10);
    send_sample(-16'sd10);
    send_sample(16'sd12345);

    // Zero gain: the state holds whatever the sample.
    set_gain('0);
    send_sample(16'sd100);
    send_sample(-16'sd32768);

    // Gain above range acts as unity.
    set_gain('1);
    send_sample(-16'sd32768);
    send_sample(16'sd32767);

    // Smallest non-zero gain: full-scale swings, truncation toward zero.
    set_gain(9'd1);
    send_sample(-16'sd32768);
    send_sample(16'sd32767);
    send_sample(16'sd5);

    // Half gain with small samples of both signs.
    set_gain(9'd128);
    send_sample(-16'sd7);
    send_sample(16'sd7);
    send_sample(-16'sd1);

    // Random phases: swap the idling sides, then run flat out.
    for (int p = 0; p < 8; p++) begin
      if (p == 3) begin
        send_idle_pct = 45;
        recv_idle_pct <= 33;
      end
      if (p == 6) begin
        send_idle_pct = 0;
        recv_idle_pct <= 0;
      end
      set_gain(phase_gain[p]);
      repeat (18) send_sample(pick_sample());
    end

    drain();
    // Catch any stray character after the last line.
    repeat (64) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
